FILE: rtl/cpu8alu_pkg.sv
// ----------------------------------------------------------------------------
// cpu8alu_pkg
// Types and command codes shared by the accumulator ALU modules.
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_ADC = 4'd1;
    localparam logic [3:0] CMD_SUB = 4'd2;
    localparam logic [3:0] CMD_SBC = 4'd3;
    localparam logic [3:0] CMD_AND = 4'd4;
    localparam logic [3:0] CMD_XOR = 4'd5;
    localparam logic [3:0] CMD_OR  = 4'd6;
    localparam logic [3:0] CMD_CP  = 4'd7;
    localparam logic [3:0] CMD_INC = 4'd8;
    localparam logic [3:0] CMD_DEC = 4'd9;
    localparam logic [3:0] CMD_CPL = 4'd10;
    localparam logic [3:0] CMD_CCF = 4'd11;
    localparam logic [3:0] CMD_SCF = 4'd12;
    localparam logic [3:0] CMD_LDA = 4'd13;
    localparam logic [3:0] CMD_LDF = 4'd14;

    localparam logic [3:0] LOW_NIBBLE = 4'hf;
    localparam logic [7:0] BYTE_MASK  = 8'hff;

    typedef struct packed {
        logic [3:0] command;
        logic [7:0] operand;
        logic       use_acc;
    } alu_in_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic [7:0] acc_out;
        logic       flag_z;
        logic       flag_n;
        logic       flag_h;
        logic       flag_c;
    } alu_out_t;

    typedef struct packed {
        logic [7:0] acc;
        logic       z;
        logic       n;
        logic       h;
        logic       c;
    } alu_state_t;

endpackage

FILE: rtl/cpu8alu_core.sv
// ----------------------------------------------------------------------------
// cpu8alu_core
// One-pass datapath: computes result byte and next accumulator/flags.
// ----------------------------------------------------------------------------
module cpu8alu_core
    import cpu8alu_pkg::*;
(
    input  alu_in_t    word,
    input  alu_state_t cur,
    output alu_state_t nxt,
    output logic [7:0] result
);

    logic [7:0] src;
    logic       cin;
    logic [8:0] sum9;
    logic [4:0] hsum5;
    logic [8:0] diff9;
    logic [4:0] hdiff5;
    logic [7:0] inc_val;
    logic [7:0] dec_val;

    assign src     = word.use_acc ? cur.acc : word.operand;
    assign cin     = (word.command inside {CMD_ADC, CMD_SBC}) ? cur.c : 1'b0;
    assign sum9    = {1'b0, cur.acc} + {1'b0, src} + {8'd0, cin};
    assign hsum5   = {1'b0, cur.acc[3:0]} + {1'b0, src[3:0]} + {4'd0, cin};
    assign diff9   = {1'b0, cur.acc} - {1'b0, src} - {8'd0, cin};
    assign hdiff5  = {1'b0, cur.acc[3:0]} - {1'b0, src[3:0]} - {4'd0, cin};
    assign inc_val = src + 8'd1;
    assign dec_val = src - 8'd1;

    always_comb
    begin
        nxt    = cur;
        result = cur.acc;
        case (word.command)
            CMD_ADD, CMD_ADC:
            begin
                result = sum9[7:0];
                nxt    = '{acc: sum9[7:0], z: (sum9[7:0] == 8'd0), n: 1'b0,
                           h: hsum5[4], c: sum9[8]};
            end
            CMD_SUB, CMD_SBC:
            begin
                result = diff9[7:0];
                nxt    = '{acc: diff9[7:0], z: (diff9[7:0] == 8'd0), n: 1'b1,
                           h: hdiff5[4], c: diff9[8]};
            end
            CMD_CP:
            begin
                // compare only: accumulator holds
                result = diff9[7:0];
                nxt    = '{acc: cur.acc, z: (diff9[7:0] == 8'd0), n: 1'b1,
                           h: hdiff5[4], c: diff9[8]};
            end
            CMD_AND:
            begin
                result = cur.acc & src;
                nxt    = '{acc: result, z: (result == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            CMD_XOR:
            begin
                result = cur.acc ^ src;
                nxt    = '{acc: result, z: (result == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_OR:
            begin
                result = cur.acc | src;
                nxt    = '{acc: result, z: (result == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_INC:
            begin
                result = inc_val;
                nxt.acc = word.use_acc ? inc_val : cur.acc;
                nxt.z   = (inc_val == 8'd0);
                nxt.n   = 1'b0;
                nxt.h   = (src[3:0] == LOW_NIBBLE);
            end
            CMD_DEC:
            begin
                result = dec_val;
                nxt.acc = word.use_acc ? dec_val : cur.acc;
                nxt.z   = (dec_val == 8'd0);
                nxt.n   = 1'b1;
                nxt.h   = (src[3:0] == 4'd0);
            end
            CMD_CPL:
            begin
                result  = cur.acc ^ BYTE_MASK;
                nxt.acc = result;
                nxt.n   = 1'b1;
                nxt.h   = 1'b1;
            end
            CMD_CCF:
            begin
                nxt.n = 1'b0;
                nxt.h = 1'b0;
                nxt.c = ~cur.c;
            end
            CMD_SCF:
            begin
                nxt.n = 1'b0;
                nxt.h = 1'b0;
                nxt.c = 1'b1;
            end
            CMD_LDA:
            begin
                result  = src;
                nxt.acc = src;
            end
            CMD_LDF:
            begin
                result = {src[7:4], 4'd0};
                nxt.z  = src[7];
                nxt.n  = src[6];
                nxt.h  = src[5];
                nxt.c  = src[4];
            end
            default:
            begin
                nxt    = cur;
                result = cur.acc;
            end
        endcase
    end

endmodule

FILE: rtl/cpu8_accumulator_alu_top.sv
// ----------------------------------------------------------------------------
// cpu8_accumulator_alu_top
// Eight-bit accumulator ALU with Z, N, H, C flags.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_data) carries one command word:
//   command code, operand byte and the accumulator-select bit.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one word per command:
//   result byte, accumulator and the four flags after that command.
//   A command accepted on cmd passes the command register, then the response
//   register, before it appears on rsp. Throughput: one command per cycle
//   while rsp_ready is high. The command register feeds a single pass of
//   8-bit add/logic; accumulator, flags and the response register load
//   together, so the next command sees the updated state at once.
//   Reset clears accumulator, flags and both valid bits.
//   When the receiver stalls, the response register holds; the command
//   register still takes one more word, then cmd_ready drops until the
//   response is taken.
// ----------------------------------------------------------------------------
module cpu8_accumulator_alu_top
    import cpu8alu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  alu_in_t  cmd_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output alu_out_t rsp_data
);

    alu_in_t    cmd_word_reg;
    logic       cmd_valid_reg;
    logic       cmd_valid_next;
    alu_state_t state_reg;
    alu_state_t state_next;
    alu_out_t   rsp_word_reg;
    alu_out_t   rsp_word_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic [7:0] result;
    logic       fire;
    logic       take;

    // advance the staged command into the result register
    assign fire = cmd_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !cmd_valid_reg || fire;
    assign take = cmd_valid && cmd_ready;

    cpu8alu_core u_core (
        .word   (cmd_word_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result)
    );

    always_comb
    begin
        cmd_valid_next = take ? 1'b1 : (fire ? 1'b0 : cmd_valid_reg);
        rsp_valid_next = fire ? 1'b1 : ((rsp_valid_reg && rsp_ready) ? 1'b0 : rsp_valid_reg);
        rsp_word_next  = '{result_byte: result, acc_out: state_next.acc,
                           flag_z: state_next.z, flag_n: state_next.n,
                           flag_h: state_next.h, flag_c: state_next.c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_word_reg <= cmd_data;
        end
        if (fire)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_word_reg;

`ifndef SYNTH
    a_acc_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_word_reg.acc_out == state_reg.acc)
        else $error("response accumulator differs from held accumulator");

    a_flags_match_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_word_reg.flag_z == state_reg.z)
                       && (rsp_word_reg.flag_n == state_reg.n)
                       && (rsp_word_reg.flag_h == state_reg.h)
                       && (rsp_word_reg.flag_c == state_reg.c))
        else $error("response flags differ from held flags");

    a_state_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("state changed without a command moving through");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> cmd_valid_reg && rsp_valid_reg && !rsp_ready)
        else $error("command stalled while a stage was free");
`endif

endmodule
